FILE: hdl/prqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and constants for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

   localparam int THREADS_DEFAULT = 64;
   localparam int LEVELS_DEFAULT  = 8;

   localparam int THREAD_ID_W = 6;
   localparam int PRIORITY_W  = 3;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [THREAD_ID_W-1:0] thread_id;
      logic [PRIORITY_W-1:0]  priority_req;
      logic                   current_ready;
   } prqs_req_type;

   typedef struct packed {
      logic [THREAD_ID_W-1:0] next_thread;
      logic                   none_ready;
   } prqs_rsp_type;

   // commands into the level table
   typedef struct packed {
      logic append;
      logic pop;
      logic head_load;
   } prqs_lvl_cmd_type;

endpackage

FILE: hdl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Multilevel priority round-robin scheduler over linked-list ready queues.
// ----------------------------------------------------------------------------
// An enqueue beat is taken from idle and keeps busy high while the old tail
// is linked. A tick goes through the pop step; the head then advances through
// the link table unless the picked thread empties its level or none is ready,
// and before the pop a valid, still-ready current thread is requeued (priority
// table read, then tail link). The sequence is set by the single write port of
// the link table and the registered reads of the priority and link tables. The
// result strobe is registered from the pop step and is high for exactly one
// cycle; the receiver cannot hold it off. No clearing pass follows reset:
// start may be raised in the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler #(
   parameter int THREADS = prqs_pkg::THREADS_DEFAULT,
   parameter int LEVELS  = prqs_pkg::LEVELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  prqs_pkg::prqs_req_type req_data,
   output logic                   rsp_strobe,
   output prqs_pkg::prqs_rsp_type rsp_data
);
   import prqs_pkg::*;

   localparam int TW = $clog2(THREADS);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RQ_PRIO  = 3'd1;
   localparam logic [2:0] ST_LINK     = 3'd2;
   localparam logic [2:0] ST_POP      = 3'd3;
   localparam logic [2:0] ST_POP_NEXT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [TW-1:0] cur_thread_ff, cur_thread_in;
   logic          cur_valid_ff, cur_valid_in;
   logic          tick_ff, tick_in;
   logic [TW-1:0] link_thread_ff, link_thread_in;
   logic [TW-1:0] link_tail_ff, link_tail_in;
   logic          link_tail_ok_ff, link_tail_ok_in;
   logic [LW-1:0] pop_level_ff, pop_level_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   prqs_rsp_type  rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             enq_ok;
   logic [TW-1:0]    enq_thread;
   logic [LW-1:0]    enq_level;
   logic             rq_ok;

   prqs_lvl_cmd_type lvl_cmd;
   logic [LW-1:0]    append_level;
   logic [TW-1:0]    append_thread;
   logic             any_nonempty;
   logic [LW-1:0]    pick_level;
   logic [TW-1:0]    pick_head;
   logic             pick_last;
   logic [TW-1:0]    old_tail;
   logic             old_nonempty;

   logic             link_wr_en;
   logic [TW-1:0]    link_wr_addr;
   logic [TW-1:0]    link_wr_data;
   logic [TW-1:0]    link_rd;
   logic             prio_wr_en;
   logic [LW-1:0]    prio_rd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign enq_ok = (req_data.op == OP_ENQUEUE)
                   && (32'(req_data.thread_id) < THREADS)
                   && (32'(req_data.priority_req) < LEVELS);
   assign enq_thread = TW'(req_data.thread_id);
   assign enq_level  = LW'(req_data.priority_req);
   assign rq_ok      = (32'(prio_rd) < LEVELS);

   // level table commands
   always_comb begin
      lvl_cmd.append    = ((state_ff == ST_IDLE) && accept && enq_ok)
                          || ((state_ff == ST_RQ_PRIO) && rq_ok);
      lvl_cmd.pop       = (state_ff == ST_POP) && any_nonempty;
      lvl_cmd.head_load = (state_ff == ST_POP_NEXT);
      append_level      = (state_ff == ST_IDLE) ? enq_level : prio_rd;
      append_thread     = (state_ff == ST_IDLE) ? enq_thread : cur_thread_ff;
   end

   // link table write port: clear the new tail's link, then chain the old tail
   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = link_tail_ff;
      link_wr_data = '0;
      priority case (1'b1)
         (state_ff == ST_IDLE) && accept && enq_ok: begin
            link_wr_en   = 1'b1;
            link_wr_addr = enq_thread;
         end
         (state_ff == ST_RQ_PRIO) && rq_ok: begin
            link_wr_en   = 1'b1;
            link_wr_addr = cur_thread_ff;
         end
         (state_ff == ST_LINK) && link_tail_ok_ff: begin
            link_wr_en   = 1'b1;
            link_wr_data = link_thread_ff;
         end
         default: begin
            link_wr_en = 1'b0;
         end
      endcase
   end

   assign prio_wr_en = (state_ff == ST_IDLE) && accept && enq_ok;

   always_comb begin
      state_in        = state_ff;
      cur_thread_in   = cur_thread_ff;
      cur_valid_in    = cur_valid_ff;
      tick_in         = tick_ff;
      link_thread_in  = link_thread_ff;
      link_tail_in    = link_tail_ff;
      link_tail_ok_in = link_tail_ok_ff;
      pop_level_in    = pop_level_ff;
      rsp_strobe_in   = 1'b0;
      rsp_data_in     = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_ENQUEUE) begin
                  if (enq_ok) begin
                     state_in        = ST_LINK;
                     tick_in         = 1'b0;
                     link_thread_in  = enq_thread;
                     link_tail_in    = old_tail;
                     link_tail_ok_in = old_nonempty;
                  end
               end else if (cur_valid_ff && req_data.current_ready) begin
                  state_in = ST_RQ_PRIO;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_RQ_PRIO: begin
            if (rq_ok) begin
               state_in        = ST_LINK;
               tick_in         = 1'b1;
               link_thread_in  = cur_thread_ff;
               link_tail_in    = old_tail;
               link_tail_ok_in = old_nonempty;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_LINK: begin
            state_in = tick_ff ? ST_POP : ST_IDLE;
         end
         ST_POP: begin
            rsp_strobe_in = 1'b1;
            if (any_nonempty) begin
               rsp_data_in.next_thread = THREAD_ID_W'(pick_head);
               rsp_data_in.none_ready  = 1'b0;
               cur_thread_in           = pick_head;
               cur_valid_in            = 1'b1;
               pop_level_in            = pick_level;
               state_in                = pick_last ? ST_IDLE : ST_POP_NEXT;
            end else begin
               rsp_data_in.next_thread = '0;
               rsp_data_in.none_ready  = 1'b1;
               cur_valid_in            = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         ST_POP_NEXT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_thread_ff <= TW'(THREADS - 1);
         cur_valid_ff  <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_thread_ff <= cur_thread_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff         <= tick_in;
      link_thread_ff  <= link_thread_in;
      link_tail_ff    <= link_tail_in;
      link_tail_ok_ff <= link_tail_ok_in;
      pop_level_ff    <= pop_level_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   prqs_levels #(
      .THREADS (THREADS),
      .LEVELS  (LEVELS)
   ) u_levels (
      .clock         (clock),
      .reset         (reset),
      .cmd           (lvl_cmd),
      .append_level  (append_level),
      .append_thread (append_thread),
      .head_level    (pop_level_ff),
      .head_value    (link_rd),
      .any_nonempty  (any_nonempty),
      .pick_level    (pick_level),
      .pick_head     (pick_head),
      .pick_last     (pick_last),
      .old_tail      (old_tail),
      .old_nonempty  (old_nonempty)
   );

   // next-thread links; read at the picked head during the pop
   prqs_ram #(
      .DEPTH (THREADS),
      .WIDTH (TW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (pick_head),
      .rd_data (link_rd)
   );

   // recorded level per thread; read at the current thread for requeue
   prqs_ram #(
      .DEPTH (THREADS),
      .WIDTH (LW)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (prio_wr_en),
      .wr_addr (enq_thread),
      .wr_data (enq_level),
      .rd_addr (cur_thread_ff),
      .rd_data (prio_rd)
   );

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_POP))
      else $error("result beat outside the pop step");

   a_none_clears_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.none_ready) |-> !cur_valid_ff)
      else $error("current thread still valid after an empty pick");

   a_direct_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == OP_TICK)
       && !(cur_valid_ff && req_data.current_ready)) |=> ##1 rsp_strobe)
      else $error("tick without requeue gave no result beat");

endmodule

FILE: hdl/prqs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prqs_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/prqs_levels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_levels
// Per-level head, tail and non-empty flags with the lowest-level pick logic.
// ----------------------------------------------------------------------------
module prqs_levels #(
   parameter int THREADS = prqs_pkg::THREADS_DEFAULT,
   parameter int LEVELS  = prqs_pkg::LEVELS_DEFAULT,
   localparam int TW = $clog2(THREADS),
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  prqs_pkg::prqs_lvl_cmd_type cmd,
   input  logic [LW-1:0]              append_level,
   input  logic [TW-1:0]              append_thread,
   input  logic [LW-1:0]              head_level,
   input  logic [TW-1:0]              head_value,
   output logic                       any_nonempty,
   output logic [LW-1:0]              pick_level,
   output logic [TW-1:0]              pick_head,
   output logic                       pick_last,
   output logic [TW-1:0]              old_tail,
   output logic                       old_nonempty
);
   import prqs_pkg::*;

   logic [TW-1:0]     head_ff [LEVELS];
   logic [TW-1:0]     tail_ff [LEVELS];
   logic [LEVELS-1:0] nonempty_ff;

   // lowest-numbered non-empty level wins
   always_comb begin
      pick_level = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            pick_level = LW'(i);
         end
      end
   end

   assign any_nonempty = |nonempty_ff;
   assign pick_head    = head_ff[pick_level];
   assign pick_last    = (head_ff[pick_level] == tail_ff[pick_level]);
   assign old_tail     = tail_ff[append_level];
   assign old_nonempty = nonempty_ff[append_level];

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
      end else begin
         if (cmd.append) begin
            nonempty_ff[append_level] <= 1'b1;
         end
         if (cmd.pop && pick_last) begin
            nonempty_ff[pick_level] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         tail_ff[append_level] <= append_thread;
         if (!nonempty_ff[append_level]) begin
            head_ff[append_level] <= append_thread;
         end
      end
      if (cmd.head_load) begin
         head_ff[head_level] <= head_value;
      end
   end

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.append && (cmd.pop || cmd.head_load)))
      else $error("level append overlaps a pop");

   a_load_live: assert property (@(posedge clock) disable iff (reset)
      cmd.head_load |-> nonempty_ff[head_level])
      else $error("head advance on an empty level");

   a_pop_live: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> nonempty_ff[pick_level])
      else $error("pop from an empty level");

endmodule
